// ----- src/hohmann_transfer_burns_assert.svh -----
// ----------------------------------------------------------------------------
// Hohmann transfer burns: assertion macros
// Shared forms for the concurrent checks, clocked on clk_i and held off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HOHMANN_TRANSFER_BURNS_ASSERT_SVH
`define HOHMANN_TRANSFER_BURNS_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define HTB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hts_pkg.sv -----
// ----------------------------------------------------------------------------
// Hohmann transfer burns: package
// Widths, fixed-point scalings, constants and status codes.
// ----------------------------------------------------------------------------
package hts_pkg;

  // field and register widths
  localparam int RADIUS_BITS_DEF = 32;
  localparam int IN_W            = 32;
  localparam int MU_W            = 50;
  localparam int DV_W            = 32;
  localparam int FT_W            = 40;

  localparam logic [MU_W-1:0] MU_RESET = 50'd398600441800000;

  // multiplier slice width
  localparam int MUL_CHUNK = 16;

  // fixed-point scalings of the quotients fed to the square roots
  localparam int CIRC_SHIFT  = 28;
  localparam int TRANS_SHIFT = 29;
  localparam int SUM_SHIFT   = 75;

  // speed difference to mm/s: round(|dv| * 1000 / 2^14)
  localparam int               MAG_W      = 40;
  localparam int               MM_SCALE_W = 10;
  localparam logic [MM_SCALE_W-1:0] MM_SCALE = 10'd1000;
  localparam int               MM_SHIFT   = 14;

  // flight time: q = (w * s) >> 4, then round(q * pi_ms / 2^55)
  localparam int              Q_SHIFT   = 4;
  localparam int              Q_W       = 64;
  localparam int              PI_W      = 32;
  localparam logic [PI_W-1:0] PI_MS_Q20 = 32'd3294198658;
  localparam int              FT_SHIFT  = 55;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ZERO_RADIUS = 2'd1,
    ST_SATURATED   = 2'd2
  } status_e;

endpackage

// ----- src/hohmann_transfer_burns.sv -----
// ----------------------------------------------------------------------------
// Hohmann transfer burns
// Burn delta-v values (mm/s) and time of flight (ms) of a Hohmann transfer
// between two circular orbits, in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  handshake                beats
//  in       in_valid_i / in_stall_o   start_radius_i, target_radius_i
//  out      out_valid_o / out_stall_i first_delta_v_o, second_delta_v_o,
//                                     flight_time_o, status_o
//  cfg      cfg_we_i                 cfg_wdata_i (gravitational parameter)
//
//  One beat enters per cycle while no held result stalls the input.
//  The restoring divider works on NW = RB + 79 bits, RB = RADIUS_BITS,
//  one bit per stage; the square root works on NW rounded up to even,
//  one bit per stage.
//  Reset empties the pipeline and loads the Earth value of the parameter.
//  A stalled result freezes every stage at once; nothing is dropped.
// ----------------------------------------------------------------------------
module hohmann_transfer_burns #(
  parameter int RADIUS_BITS = hts_pkg::RADIUS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hts_pkg::MU_W-1:0]        cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hts_pkg::IN_W-1:0]        start_radius_i,
  input  logic [hts_pkg::IN_W-1:0]        target_radius_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [hts_pkg::DV_W-1:0] first_delta_v_o,
  output logic signed [hts_pkg::DV_W-1:0] second_delta_v_o,
  output logic [hts_pkg::FT_W-1:0]        flight_time_o,
  output logic [1:0]                      status_o
);

  localparam int RB    = RADIUS_BITS;
  localparam int MU_W  = hts_pkg::MU_W;
  localparam int DV_W  = hts_pkg::DV_W;
  localparam int FT_W  = hts_pkg::FT_W;
  localparam int MAG_W = hts_pkg::MAG_W;
  localparam int Q_W   = hts_pkg::Q_W;
  localparam int SUM_W = RB + 1;
  localparam int PW1   = MU_W + RB;
  localparam int NW    = MU_W + RB + hts_pkg::TRANS_SHIFT;
  localparam int DW    = (2 * RB + 1 > MU_W) ? 2 * RB + 1 : MU_W;
  localparam int XW    = NW + (NW % 2);
  localparam int H     = XW / 2;
  localparam int PW2   = H + SUM_W;
  localparam int PW3   = Q_W + hts_pkg::PI_W;
  localparam int TW    = PW3 + 1;
  localparam int MW    = MAG_W + hts_pkg::MM_SCALE_W + 1;
  localparam int S1_W  = 1 + RB + RB + SUM_W;
  localparam int S2_W  = 2 + SUM_W;
  localparam int S3_W  = 2 + 2 * (1 + MAG_W);
  localparam int S4_W  = 4 + 2 * DV_W;

  localparam logic [DV_W-1:0] DV_POS_MAX = {1'b0, {(DV_W-1){1'b1}}};
  localparam logic [DV_W-1:0] DV_NEG_MAX = {1'b1, {(DV_W-1){1'b0}}};
  localparam logic [TW-1:0]   FT_HALF    = TW'(1) << (hts_pkg::FT_SHIFT - 1);

  typedef struct packed {
    logic [DV_W-1:0] bits;
    logic            sat;
  } mm_t;

  // speed difference in 2^-14 m/s to signed mm/s, saturating
  function automatic mm_t to_mm(input logic neg, input logic [MAG_W-1:0] mag);
    logic [MW-1:0] m;
    mm_t           r;
    m = (MW'(mag) * MW'(hts_pkg::MM_SCALE) + (MW'(1) << (hts_pkg::MM_SHIFT - 1)))
        >> hts_pkg::MM_SHIFT;
    r.sat = 1'b0;
    if (!neg) begin
      if (m > MW'(DV_POS_MAX)) begin
        r.sat  = 1'b1;
        r.bits = DV_POS_MAX;
      end else begin
        r.bits = DV_W'(m);
      end
    end else begin
      if (m > MW'(DV_NEG_MAX)) begin
        r.sat  = 1'b1;
        r.bits = DV_NEG_MAX;
      end else begin
        r.bits = DV_W'(-m);
      end
    end
    return r;
  endfunction

  logic en;

  // ---------------------------------------------------------------- config
  logic [MU_W-1:0] mu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q <= hts_pkg::MU_RESET;
    end else if (cfg_we_i) begin
      mu_q <= cfg_wdata_i;
    end
  end

  // ------------------------------------------------ stall: freeze all stages
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ------------------------------------------------- input stage: mask, sum
  logic             a_valid_q;
  logic [RB-1:0]    a_r1_q;
  logic [RB-1:0]    a_r2_q;
  logic [SUM_W-1:0] a_s_q;
  logic             a_zero_q;
  logic [RB-1:0]    r1_in;
  logic [RB-1:0]    r2_in;

  assign r1_in = RB'(start_radius_i);
  assign r2_in = RB'(target_radius_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i && !in_stall_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_r1_q   <= r1_in;
      a_r2_q   <= r2_in;
      a_s_q    <= SUM_W'(r1_in) + SUM_W'(r2_in);
      a_zero_q <= (r1_in == '0) || (r2_in == '0);
    end
  end

  // -------------------------------- products: mu*r2, mu*r1, r1*s and r2*s
  logic [3:0][MU_W-1:0] m1_a;
  logic [3:0][RB-1:0]   m1_b;
  logic                 m1_valid;
  logic [3:0][PW1-1:0]  m1_prod;
  logic [S1_W-1:0]      m1_side;
  logic                 m1_zero;
  logic [RB-1:0]        m1_r1;
  logic [RB-1:0]        m1_r2;
  logic [SUM_W-1:0]     m1_s;

  assign m1_a[0] = mu_q;
  assign m1_b[0] = a_r2_q;
  assign m1_a[1] = mu_q;
  assign m1_b[1] = a_r1_q;
  assign m1_a[2] = MU_W'(a_s_q);
  assign m1_b[2] = a_r1_q;
  assign m1_a[3] = MU_W'(a_s_q);
  assign m1_b[3] = a_r2_q;

  hts_mul #(
    .LANES (4),
    .AW    (MU_W),
    .BW    (RB),
    .SW    (S1_W)
  ) u_mul_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_valid_q),
    .a_i     (m1_a),
    .b_i     (m1_b),
    .side_i  ({a_zero_q, a_r1_q, a_r2_q, a_s_q}),
    .valid_o (m1_valid),
    .prod_o  (m1_prod),
    .side_o  (m1_side)
  );

  assign {m1_zero, m1_r1, m1_r2, m1_s} = m1_side;

  // ------------------------------------------------------------- quotients
  logic [4:0][NW-1:0] dv_num;
  logic [4:0][DW-1:0] dv_den;
  logic               dq_valid;
  logic [4:0][NW-1:0] dq_quo;
  logic [S2_W-1:0]    dq_side;

  assign dv_num[0] = NW'(mu_q) << hts_pkg::CIRC_SHIFT;
  assign dv_den[0] = DW'(m1_r1);
  assign dv_num[1] = NW'(mu_q) << hts_pkg::CIRC_SHIFT;
  assign dv_den[1] = DW'(m1_r2);
  assign dv_num[2] = NW'(m1_prod[0]) << hts_pkg::TRANS_SHIFT;
  assign dv_den[2] = DW'(m1_prod[2]);
  assign dv_num[3] = NW'(m1_prod[1]) << hts_pkg::TRANS_SHIFT;
  assign dv_den[3] = DW'(m1_prod[3]);
  assign dv_num[4] = NW'(m1_s) << hts_pkg::SUM_SHIFT;
  assign dv_den[4] = DW'(mu_q);

  hts_div #(
    .LANES (5),
    .NW    (NW),
    .DW    (DW),
    .SW    (S2_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m1_valid),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .side_i  ({m1_zero, mu_q == '0, m1_s}),
    .valid_o (dq_valid),
    .quo_o   (dq_quo),
    .side_o  (dq_side)
  );

  // ----------------------------------------------------------- square roots
  logic [4:0][XW-1:0] sq_rad;
  logic               sq_valid;
  logic [4:0][H-1:0]  sq_root;
  logic [S2_W-1:0]    sq_side;

  for (genvar l = 0; l < 5; l++) begin : g_rad
    assign sq_rad[l] = XW'(dq_quo[l]);
  end

  hts_sqrt #(
    .LANES (5),
    .XW    (XW),
    .SW    (S2_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dq_valid),
    .rad_i   (sq_rad),
    .side_i  (dq_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // --------------------------------------- speed differences: dv1 and dv2
  logic             e_valid_q;
  logic [H-1:0]     e_w_q;
  logic [SUM_W-1:0] e_s_q;
  logic             e_zero_q;
  logic             e_muz_q;
  logic             e_neg1_q;
  logic [MAG_W-1:0] e_mag1_q;
  logic             e_neg2_q;
  logic [MAG_W-1:0] e_mag2_q;
  logic             neg1;
  logic             neg2;

  // dv1 = vt1 - vc1, dv2 = vc2 - vt2
  assign neg1 = sq_root[2] < sq_root[0];
  assign neg2 = sq_root[1] < sq_root[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_w_q    <= sq_root[4];
      {e_zero_q, e_muz_q, e_s_q} <= sq_side;
      e_neg1_q <= neg1;
      e_mag1_q <= MAG_W'(neg1 ? sq_root[0] - sq_root[2] : sq_root[2] - sq_root[0]);
      e_neg2_q <= neg2;
      e_mag2_q <= MAG_W'(neg2 ? sq_root[3] - sq_root[1] : sq_root[1] - sq_root[3]);
    end
  end

  // ---------------------------------------------------------- product w*s
  logic             m2_valid;
  logic [PW2-1:0]   m2_prod;
  logic [S3_W-1:0]  m2_side;
  logic             m2_zero;
  logic             m2_muz;
  logic             m2_neg1;
  logic [MAG_W-1:0] m2_mag1;
  logic             m2_neg2;
  logic [MAG_W-1:0] m2_mag2;

  hts_mul #(
    .LANES (1),
    .AW    (H),
    .BW    (SUM_W),
    .SW    (S3_W)
  ) u_mul_ws (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_valid_q),
    .a_i     (e_w_q),
    .b_i     (e_s_q),
    .side_i  ({e_zero_q, e_muz_q, e_neg1_q, e_mag1_q, e_neg2_q, e_mag2_q}),
    .valid_o (m2_valid),
    .prod_o  (m2_prod),
    .side_o  (m2_side)
  );

  assign {m2_zero, m2_muz, m2_neg1, m2_mag1, m2_neg2, m2_mag2} = m2_side;

  // ---------------------------------- mm/s conversion, time-over-pi check
  logic            f_valid_q;
  logic [Q_W-1:0]  f_q_q;
  logic            f_qover_q;
  logic [DV_W-1:0] f_dv1_q;
  logic [DV_W-1:0] f_dv2_q;
  logic            f_dvsat_q;
  logic            f_zero_q;
  logic            f_muz_q;
  mm_t             mm1;
  mm_t             mm2;

  assign mm1 = to_mm(m2_neg1, m2_mag1);
  assign mm2 = to_mm(m2_neg2, m2_mag2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= m2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q_q     <= Q_W'(m2_prod >> hts_pkg::Q_SHIFT);
      f_qover_q <= (m2_prod >> (hts_pkg::Q_SHIFT + Q_W)) != '0;
      f_dv1_q   <= mm1.bits;
      f_dv2_q   <= mm2.bits;
      f_dvsat_q <= mm1.sat || mm2.sat;
      f_zero_q  <= m2_zero;
      f_muz_q   <= m2_muz;
    end
  end

  // ------------------------------------------------------ product q*pi_ms
  logic            g_valid;
  logic [PW3-1:0]  g_prod;
  logic [S4_W-1:0] g_side;
  logic            g_zero;
  logic            g_muz;
  logic            g_dvsat;
  logic            g_qover;
  logic [DV_W-1:0] g_dv1;
  logic [DV_W-1:0] g_dv2;

  hts_mul #(
    .LANES (1),
    .AW    (Q_W),
    .BW    (hts_pkg::PI_W),
    .SW    (S4_W)
  ) u_mul_pi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid_q),
    .a_i     (f_q_q),
    .b_i     (hts_pkg::PI_MS_Q20),
    .side_i  ({f_zero_q, f_muz_q, f_dvsat_q, f_qover_q, f_dv1_q, f_dv2_q}),
    .valid_o (g_valid),
    .prod_o  (g_prod),
    .side_o  (g_side)
  );

  assign {g_zero, g_muz, g_dvsat, g_qover, g_dv1, g_dv2} = g_side;

  // ------------------------------------- round time, saturate, set status
  logic [TW-1:0]    t_ms;
  logic             ft_sat;
  logic [FT_W-1:0]  ft;
  logic [DV_W-1:0]  out_dv1_q;
  logic [DV_W-1:0]  out_dv2_q;
  logic [FT_W-1:0]  out_ft_q;
  hts_pkg::status_e out_status_q;
  hts_pkg::status_e status_d;

  always_comb begin
    t_ms   = (TW'(g_prod) + FT_HALF) >> hts_pkg::FT_SHIFT;
    ft_sat = g_muz || g_qover || ((t_ms >> FT_W) != '0);
    ft     = ft_sat ? '1 : FT_W'(t_ms);
    if (g_zero) begin
      status_d = hts_pkg::ST_ZERO_RADIUS;
    end else if (g_dvsat || ft_sat) begin
      status_d = hts_pkg::ST_SATURATED;
    end else begin
      status_d = hts_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= g_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_dv1_q    <= g_zero ? '0 : g_dv1;
      out_dv2_q    <= g_zero ? '0 : g_dv2;
      out_ft_q     <= g_zero ? '0 : ft;
      out_status_q <= status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign first_delta_v_o  = $signed(out_dv1_q);
  assign second_delta_v_o = $signed(out_dv2_q);
  assign flight_time_o    = out_ft_q;
  assign status_o         = out_status_q;

  // ------------------------------------------------------------ assertions
  `include "hohmann_transfer_burns_assert.svh"

  `HTB_ASSERT_NOW(a_zero_clears, out_valid_o && status_o == hts_pkg::ST_ZERO_RADIUS, first_delta_v_o == '0 && second_delta_v_o == '0 && flight_time_o == '0, "zero radius result not cleared")
  `HTB_ASSERT_NOW(a_stall_back, out_valid_o && out_stall_i, in_stall_o, "input taken while result held")
  `HTB_ASSERT_NEXT(a_result_lands, g_valid && !in_stall_o, out_valid_o, "result lost at output stage")

endmodule

// ----- src/hts_mul.sv -----
// ----------------------------------------------------------------------------
// Hohmann transfer burns: pipelined multiplier
// Multiplies each lane's a by b, one slice of b per stage, accumulating
// partial products; a side word travels along unchanged.
// ----------------------------------------------------------------------------
module hts_mul #(
  parameter int LANES = 1,
  parameter int AW    = 16,
  parameter int BW    = 16,
  parameter int SW    = 1,
  parameter int CW    = hts_pkg::MUL_CHUNK
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][AW-1:0]    a_i,
  input  logic [LANES-1:0][BW-1:0]    b_i,
  input  logic [SW-1:0]               side_i,
  output logic                        valid_o,
  output logic [LANES-1:0][AW+BW-1:0] prod_o,
  output logic [SW-1:0]               side_o
);

  localparam int NS = (BW + CW - 1) / CW;
  localparam int BP = NS * CW;
  localparam int PW = AW + BW;
  localparam int XW = PW + BP;

  logic                     valid_q [NS];
  logic [LANES-1:0][AW-1:0] a_q     [NS];
  logic [LANES-1:0][BP-1:0] b_q     [NS];
  logic [LANES-1:0][PW-1:0] acc_q   [NS];
  logic [SW-1:0]            side_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                        v_in;
    logic [LANES-1:0][AW-1:0]    a_in;
    logic [LANES-1:0][BP-1:0]    b_in;
    logic [LANES-1:0][PW-1:0]    acc_in;
    logic [SW-1:0]               side_in;
    logic [LANES-1:0][AW+CW-1:0] pp;
    logic [LANES-1:0][PW-1:0]    acc_d;

    // pick the stage inputs
    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign a_in    = a_i;
      assign acc_in  = '0;
      assign side_in = side_i;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign b_in[l] = BP'(b_i[l]);
      end
    end else begin : g_body
      assign v_in    = valid_q[k-1];
      assign a_in    = a_q[k-1];
      assign b_in    = b_q[k-1];
      assign acc_in  = acc_q[k-1];
      assign side_in = side_q[k-1];
    end

    // add one slice's partial product
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        pp[l]    = (AW+CW)'(a_in[l]) * (AW+CW)'(b_in[l][k*CW +: CW]);
        acc_d[l] = acc_in[l] + PW'(XW'(pp[l]) << (k*CW));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k]    <= a_in;
        b_q[k]    <= b_in;
        acc_q[k]  <= acc_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign prod_o  = acc_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

// ----- src/hts_div.sv -----
// ----------------------------------------------------------------------------
// Hohmann transfer burns: pipelined divider
// Restoring division, one quotient bit per stage, for several lanes at once;
// a side word travels along unchanged.
// ----------------------------------------------------------------------------
module hts_div #(
  parameter int LANES = 1,
  parameter int NW    = 16,
  parameter int DW    = 16,
  parameter int SW    = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [LANES-1:0][NW-1:0] num_i,
  input  logic [LANES-1:0][DW-1:0] den_i,
  input  logic [SW-1:0]            side_i,
  output logic                     valid_o,
  output logic [LANES-1:0][NW-1:0] quo_o,
  output logic [SW-1:0]            side_o
);

  logic                     valid_q [NW];
  logic [LANES-1:0][NW-1:0] nq_q    [NW];
  logic [LANES-1:0][DW-1:0] rem_q   [NW];
  logic [LANES-1:0][DW-1:0] den_q   [NW];
  logic [SW-1:0]            side_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic                     v_in;
    logic [LANES-1:0][NW-1:0] nq_in;
    logic [LANES-1:0][DW-1:0] rem_in;
    logic [LANES-1:0][DW-1:0] den_in;
    logic [SW-1:0]            side_in;
    logic [LANES-1:0][DW:0]   t;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][NW-1:0] nq_d;
    logic [LANES-1:0][DW-1:0] rem_d;

    // pick the stage inputs
    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign nq_in   = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_body
      assign v_in    = valid_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]     = {rem_in[l], nq_in[l][NW-1]};
        ge[l]    = t[l] >= {1'b0, den_in[l]};
        rem_d[l] = ge[l] ? DW'(t[l] - {1'b0, den_in[l]}) : t[l][DW-1:0];
        nq_d[l]  = {nq_in[l][NW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]   <= nq_d;
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NW-1];
  assign quo_o   = nq_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

// ----- src/hts_sqrt.sv -----
// ----------------------------------------------------------------------------
// Hohmann transfer burns: pipelined square root
// Floor square root, one root bit per stage, for several lanes at once;
// a side word travels along unchanged.
// ----------------------------------------------------------------------------
module hts_sqrt #(
  parameter int LANES = 1,
  parameter int XW    = 16,
  parameter int SW    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LANES-1:0][XW-1:0]   rad_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][XW/2-1:0] root_o,
  output logic [SW-1:0]              side_o
);

  localparam int H = XW / 2;

  logic                     valid_q [H];
  logic [LANES-1:0][XW-1:0] x_q     [H];
  logic [LANES-1:0][H-1:0]  rem_q   [H];
  logic [LANES-1:0][H-1:0]  root_q  [H];
  logic [SW-1:0]            side_q  [H];

  for (genvar k = 0; k < H; k++) begin : g_stage
    logic                     v_in;
    logic [LANES-1:0][XW-1:0] x_in;
    logic [LANES-1:0][H-1:0]  rem_in;
    logic [LANES-1:0][H-1:0]  root_in;
    logic [SW-1:0]            side_in;
    logic [LANES-1:0][H+1:0]  t;
    logic [LANES-1:0][H+1:0]  trial;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][XW-1:0] x_d;
    logic [LANES-1:0][H-1:0]  rem_d;
    logic [LANES-1:0][H-1:0]  root_d;

    // pick the stage inputs
    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign x_in    = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign v_in    = valid_q[k-1];
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down two bits, try root*4+1
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]      = {rem_in[l], x_in[l][XW-1 -: 2]};
        trial[l]  = {root_in[l], 2'b01};
        ge[l]     = t[l] >= trial[l];
        rem_d[l]  = ge[l] ? H'(t[l] - trial[l]) : t[l][H-1:0];
        root_d[l] = {root_in[l][H-2:0], ge[l]};
        x_d[l]    = {x_in[l][XW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_d;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[H-1];
  assign root_o  = root_q[H-1];
  assign side_o  = side_q[H-1];

endmodule

// ----- verif/hohmann_transfer_burns_checker.sv -----
// ----------------------------------------------------------------------------
// Hohmann transfer burns: result checker
// Watches the parameter writes and both channels, works out the burns and the
// flight time of every accepted radius pair and compares each result beat
// with the oldest one awaited.
// ----------------------------------------------------------------------------
module hohmann_transfer_burns_checker
  import hts_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [MU_W-1:0]        cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [IN_W-1:0]        start_radius_i,
  input  logic [IN_W-1:0]        target_radius_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic signed [DV_W-1:0] first_delta_v_i,
  input  logic signed [DV_W-1:0] second_delta_v_i,
  input  logic [FT_W-1:0]        flight_time_i,
  input  logic [1:0]             status_i,
  output int                     mismatch_count_o,
  output int                     awaited_count_o
);

  typedef struct packed {
    logic [DV_W-1:0] dv1;
    logic [DV_W-1:0] dv2;
    logic [FT_W-1:0] ft;
    status_e         status;
  } burns_t;

  localparam logic [FT_W-1:0] FT_MAX = '1;

  logic [MU_W-1:0] grav_mu;
  burns_t          awaited_burns[$];

  assign awaited_count_o = awaited_burns.size();

  // floor square root, one result bit per pass
  function automatic logic [63:0] floor_root(logic [127:0] x);
    logic [127:0] rem;
    logic [127:0] root;
    logic [127:0] bitv;
    rem  = x;
    root = '0;
    bitv = 128'd1 << 126;
    for (int i = 0; i < 64; i++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[63:0];
  endfunction

  // speed difference in 2^-14 m/s to rounded mm/s, saturated
  function automatic logic [DV_W-1:0] speed_to_mm(logic [63:0] plus, logic [63:0] minus,
                                                  inout logic sat);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] mm;
    neg = plus < minus;
    mag = neg ? minus - plus : plus - minus;
    mm  = (mag * 64'd1000 + 64'd8192) >> MM_SHIFT;
    if (!neg) begin
      if (mm > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        mm  = 64'h7FFF_FFFF;
      end
      return mm[DV_W-1:0];
    end
    if (mm > 64'h8000_0000) begin
      sat = 1'b1;
      mm  = 64'h8000_0000;
    end
    return -mm[DV_W-1:0];
  endfunction

  function automatic burns_t burn_figures(logic [IN_W-1:0] r1, logic [IN_W-1:0] r2,
                                          logic [MU_W-1:0] mu);
    burns_t       b;
    logic         sat;
    logic [127:0] s;
    logic [63:0]  vc1, vc2, vt1, vt2, w;
    logic [127:0] q;
    logic [127:0] t;
    b   = '0;
    sat = 1'b0;
    if (r1 == 0 || r2 == 0) begin
      b.status = ST_ZERO_RADIUS;
      return b;
    end
    s   = 128'(r1) + 128'(r2);
    vc1 = floor_root((128'(mu) << CIRC_SHIFT) / 128'(r1));
    vc2 = floor_root((128'(mu) << CIRC_SHIFT) / 128'(r2));
    vt1 = floor_root(((128'(mu) * 128'(r2)) << TRANS_SHIFT) / (128'(r1) * s));
    vt2 = floor_root(((128'(mu) * 128'(r1)) << TRANS_SHIFT) / (128'(r2) * s));
    b.dv1 = speed_to_mm(vt1, vc1, sat);
    b.dv2 = speed_to_mm(vc2, vt2, sat);
    if (mu == 0) begin
      b.ft = FT_MAX;
      sat  = 1'b1;
    end else begin
      w = floor_root((s << SUM_SHIFT) / 128'(mu));
      q = (128'(w) * s) >> Q_SHIFT;
      if (q[127:64] != 0) begin
        b.ft = FT_MAX;
        sat  = 1'b1;
      end else begin
        t = (q * 128'(PI_MS_Q20) + (128'd1 << 54)) >> FT_SHIFT;
        if (t > 128'(FT_MAX)) begin
          b.ft = FT_MAX;
          sat  = 1'b1;
        end else begin
          b.ft = t[FT_W-1:0];
        end
      end
    end
    b.status = sat ? ST_SATURATED : ST_OK;
    return b;
  endfunction

  // track the parameter, queue a prediction per input beat, check output beats
  always @(posedge clk_i or negedge rst_ni) begin
    burns_t want;
    if (!rst_ni) begin
      grav_mu          <= MU_RESET;
      mismatch_count_o <= 0;
      awaited_burns.delete();
    end else begin
      if (cfg_we_i) begin
        grav_mu <= cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_burns.push_back(burn_figures(start_radius_i, target_radius_i, grav_mu));
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_burns.size() == 0) begin
          $error("result beat with nothing awaited");
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = awaited_burns.pop_front();
          if (first_delta_v_i !== want.dv1 || second_delta_v_i !== want.dv2 ||
              flight_time_i !== want.ft || status_i !== want.status) begin
            mismatch_count_o <= mismatch_count_o + 1;
          end
          if (first_delta_v_i !== want.dv1)
            $error("first_delta_v: expected %0d, got %0d", $signed(want.dv1),
                   first_delta_v_i);
          if (second_delta_v_i !== want.dv2)
            $error("second_delta_v: expected %0d, got %0d", $signed(want.dv2),
                   second_delta_v_i);
          if (flight_time_i !== want.ft)
            $error("flight_time: expected %0d, got %0d", want.ft, flight_time_i);
          if (status_i !== want.status)
            $error("status: expected %0d, got %0d", want.status, status_i);
        end
      end
    end
  end

endmodule

// ----- verif/hohmann_transfer_burns_test.sv -----
// ----------------------------------------------------------------------------
// Hohmann transfer burns: testbench top
// Drives radius pairs and parameter writes into the block, stalls the result
// side at random and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module hohmann_transfer_burns_test;
  import hts_pkg::*;

  localparam int              RANDOM_BEATS = 1930;
  localparam int              DRAIN_CYCLES = 220;
  localparam logic [MU_W-1:0] MU_MAX       = '1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [MU_W-1:0]        cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [IN_W-1:0]        start_radius_i = '0;
  logic [IN_W-1:0]        target_radius_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [DV_W-1:0] first_delta_v_o;
  logic signed [DV_W-1:0] second_delta_v_o;
  logic [FT_W-1:0]        flight_time_o;
  logic [1:0]             status_o;
  int                     mismatch_count;
  int                     awaited_count;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;

  always #6 clk_i = ~clk_i;

  hohmann_transfer_burns dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .start_radius_i   (start_radius_i),
    .target_radius_i  (target_radius_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .first_delta_v_o  (first_delta_v_o),
    .second_delta_v_o (second_delta_v_o),
    .flight_time_o    (flight_time_o),
    .status_o         (status_o)
  );

  hohmann_transfer_burns_checker burn_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .start_radius_i   (start_radius_i),
    .target_radius_i  (target_radius_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .first_delta_v_i  (first_delta_v_o),
    .second_delta_v_i (second_delta_v_o),
    .flight_time_i    (flight_time_o),
    .status_i         (status_o),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count)
  );

  // stall the result side at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // offer one radius pair, after an optional random gap, and hold until taken
  task automatic send_radii(logic [IN_W-1:0] r1, logic [IN_W-1:0] r2);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    start_radius_i  <= r1;
    target_radius_i <= r2;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // drain the pipeline, then write the parameter
  task automatic write_mu(logic [MU_W-1:0] mu);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mu;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [IN_W-1:0] pick_radius();
    case ($urandom_range(9))
      0:       return $urandom_range(3) == 0 ? '0 : IN_W'($urandom_range(15));
      1, 2:    return IN_W'($urandom_range(1 << 16));
      3, 4, 5: return IN_W'($urandom_range(6_400_000, 500_000_000));
      default: return $urandom();
    endcase
  endfunction

  task automatic random_beats(int n);
    logic [IN_W-1:0] r1;
    for (int i = 0; i < n; i++) begin
      r1 = pick_radius();
      // near-equal orbits now and then
      if ($urandom_range(7) == 0) send_radii(r1, r1 + IN_W'($urandom_range(2)));
      else send_radii(r1, pick_radius());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero radii, extremes, equal orbits, realistic transfers
    send_radii('0, 32'd7_000_000);
    send_radii(32'd7_000_000, '0);
    send_radii('0, '0);
    send_radii(32'd1, 32'd1);
    send_radii(32'd1, 32'd2);
    send_radii('1, '1);
    send_radii(32'd1, '1);
    send_radii('1, 32'd1);
    send_radii(32'd6_778_000, 32'd42_164_000);
    send_radii(32'd42_164_000, 32'd6_778_000);
    send_radii(32'd7_000_000, 32'd7_000_000);
    send_radii(32'h5555_5555, 32'hAAAA_AAAA);
    send_radii(32'hAAAA_AAAA, 32'h5555_5555);
    write_mu(MU_MAX);
    send_radii(32'd1, '1);
    send_radii('1, 32'd1);
    send_radii(32'd1, 32'd2);
    write_mu(50'd1);
    send_radii('1, '1);
    send_radii(32'd1, 32'd1);
    send_radii(32'd6_778_000, 32'd42_164_000);

    // random: receiver idles more, then sender, then neither
    send_idle_pct = 33;
    recv_idle_pct = 73;
    write_mu(MU_MAX);
    random_beats(RANDOM_BEATS / 3);
    send_idle_pct = 73;
    recv_idle_pct = 33;
    write_mu(50'd1);
    random_beats(RANDOM_BEATS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mu(MU_W'({$urandom_range(1 << 17, 1), $urandom()}) | 50'd1);
    random_beats(RANDOM_BEATS / 6);
    write_mu(MU_RESET);
    random_beats(RANDOM_BEATS / 6);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // stop a hung run
  initial begin
    #(12 * 800_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
